### sv/assert_macros.svh
// Assertion macros shared by the cursor controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on clk_i, idle during reset.
`define ASSERT_CLK(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cursor controller assertion failed");

// Next-cycle implication on clk_i, idle during reset.
`define ASSERT_CLK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cursor controller assertion failed");

`endif

### sv/tcc_pkg.sv
// Types, constants and codes of the text cursor controller.
`default_nettype none

package tcc_pkg;

  localparam int unsigned CELL_WIDTH  = 8;
  localparam int unsigned CELL_HEIGHT = 16;

  localparam int unsigned COORD_W  = 11;
  // Headroom for cursor + two line steps + one check step (below 4096).
  localparam int unsigned WORK_W   = COORD_W + 1;
  localparam int unsigned ZOOM_W   = 4;
  localparam int unsigned ZOOM_MAX = 2**ZOOM_W - 1;
  localparam int unsigned CW_W     = $clog2(CELL_WIDTH * ZOOM_MAX + 1);
  localparam int unsigned LH_W     = $clog2(CELL_HEIGHT * ZOOM_MAX + 1);
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned COL_W    = 8;
  localparam int unsigned ROW_W    = 7;
  localparam int unsigned LINES_W  = 8;
  localparam int unsigned NX_W     = CW_W + COL_W;
  localparam int unsigned NY_W     = LH_W + ROW_W;

  localparam int unsigned DIV_STEPS = COORD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [COORD_W-1:0] COORD_MAX      = '1;
  localparam logic [COORD_W-1:0] WIDTH_RESET    = COORD_W'(1024);
  localparam logic [COORD_W-1:0] HEIGHT_RESET   = COORD_W'(768);
  localparam logic [ZOOM_W-1:0]  ZOOM_RESET     = ZOOM_W'(2);
  localparam logic [CHAR_W-1:0]  CHAR_NEWLINE   = CHAR_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_BACKSPACE = CHAR_W'(8);
  localparam logic [CHAR_W-1:0]  CHAR_SPACE     = CHAR_W'(32);

  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_GLYPH = 2'd1,
    ACT_ERASE = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_DISP_WIDTH  = 2'd0,
    REG_DISP_HEIGHT = 2'd1,
    REG_ZOOM        = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [CHAR_W-1:0]  glyph_code;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               scroll;
    logic [LINES_W-1:0] scroll_lines;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] disp_width;
    logic [COORD_W-1:0] disp_height;
    logic [ZOOM_W-1:0]  zoom;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_start;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### sv/tcc_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module tcc_regs
  import tcc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_DISP_WIDTH:  cfg_d.disp_width  = pwdata[COORD_W-1:0];
        REG_DISP_HEIGHT: cfg_d.disp_height = pwdata[COORD_W-1:0];
        REG_ZOOM:        cfg_d.zoom        = pwdata[ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.disp_width  <= WIDTH_RESET;
      cfg_q.disp_height <= HEIGHT_RESET;
      cfg_q.zoom        <= ZOOM_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DISP_WIDTH:  prdata = APB_DATA_W'(cfg_q.disp_width);
      REG_DISP_HEIGHT: prdata = APB_DATA_W'(cfg_q.disp_height);
      REG_ZOOM:        prdata = APB_DATA_W'(cfg_q.zoom);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### sv/tcc_ctrl.sv
// Sequencing state machine of the cursor controller.
`default_nettype none
`include "assert_macros.svh"

module tcc_ctrl
  import tcc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  dp_status_t      sts_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register can take the item
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  `ASSERT_CLK_NEXT(a_accept_to_prep, in_valid_i && in_ready_o, state_q == S_PREP)
  `ASSERT_CLK_NEXT(a_div_to_done, state_q == S_DIV && sts_i.div_last, state_q == S_DONE)
  `ASSERT_CLK_NEXT(a_commit_to_idle, cmd_o.commit, state_q == S_IDLE)

endmodule

`default_nettype wire

### sv/tcc_dp.sv
// Datapath: cursor registers, remainder divider, next-cursor logic, output register.
`default_nettype none
`include "assert_macros.svh"

module tcc_dp
  import tcc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  cfg_t            cfg_i,
  input  in_item_t        in_item_i,
  input  ctrl_cmd_t       cmd_i,
  output dp_status_t      sts_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_item_o
);

  in_item_t               item_q;
  logic [COORD_W-1:0]     cur_x_q, cur_y_q, cur_x_d, cur_y_d;
  logic [NX_W-1:0]        nx_q;
  logic [NY_W-1:0]        ny_q;
  logic [CW_W-1:0]        rem_q, rem_d;
  logic [COORD_W-1:0]     dvd_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  out_item_t              out_q, res;
  logic                   out_valid_q;

  logic [ZOOM_W-1:0]      z;
  logic [CW_W-1:0]        cw;
  logic [LH_W-1:0]        lh;
  logic [CW_W:0]          trial;
  logic                   out_busy;

  logic [WORK_W-1:0]      x0, y0, x1, y1, x2, y2, y3, cw_w, lh_w, sw_w, sh_w;

  assign z    = (cfg_i.zoom == '0) ? ZOOM_W'(1) : cfg_i.zoom;
  assign cw   = CW_W'(z * CELL_WIDTH);
  assign lh   = LH_W'(z * CELL_HEIGHT);
  assign cw_w = WORK_W'(cw);
  assign lh_w = WORK_W'(lh);
  assign sw_w = WORK_W'(cfg_i.disp_width);
  assign sh_w = WORK_W'(cfg_i.disp_height);
  assign x0   = WORK_W'(cur_x_q);
  assign y0   = WORK_W'(cur_y_q);

  // Backspace at line start needs display width mod cell width.
  assign sts_o.need_div = (item_q.func == FUNC_PUT) && (item_q.char_code == CHAR_BACKSPACE)
                          && (x0 == '0) && (y0 >= lh_w);
  assign sts_o.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign out_busy       = out_valid_q && !out_ready_i;
  assign sts_o.out_busy = out_busy;

  // Restoring remainder step, one dividend bit per cycle.
  assign trial = {rem_q, dvd_q[COORD_W-1]};
  assign rem_d = (trial >= (CW_W+1)'(cw)) ? CW_W'(trial - (CW_W+1)'(cw)) : trial[CW_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    if (cmd_i.prep) begin
      nx_q <= NX_W'(cw) * NX_W'(item_q.column);
      ny_q <= NY_W'(lh) * NY_W'(item_q.row);
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      dvd_q <= cfg_i.disp_width;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[COORD_W-2:0], 1'b0};
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  always_comb begin
    res     = '0;
    x1      = x0;
    y1      = y0;
    x2      = x0;
    y2      = y0;
    y3      = y0;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    unique case (item_q.func)
      FUNC_PUT: begin
        if (item_q.char_code == CHAR_NEWLINE) begin
          x1 = '0;
          y1 = y0 + lh_w;
        end else if (item_q.char_code == CHAR_BACKSPACE) begin
          if (x0 >= cw_w) begin
            x1             = x0 - cw_w;
            res.action     = ACT_ERASE;
            res.glyph_code = CHAR_SPACE;
            res.cell_x     = x1[COORD_W-1:0];
            res.cell_y     = y0[COORD_W-1:0];
          end else if (sts_o.need_div) begin
            // last whole cell of the line above: width - rem - cell width
            y1             = y0 - lh_w;
            x1             = (sw_w >= cw_w) ? sw_w - WORK_W'(rem_q) - cw_w : '0;
            res.action     = ACT_ERASE;
            res.glyph_code = CHAR_SPACE;
            res.cell_x     = x1[COORD_W-1:0];
            res.cell_y     = y1[COORD_W-1:0];
          end
        end else begin
          res.action     = ACT_GLYPH;
          res.glyph_code = item_q.char_code;
          res.cell_x     = cur_x_q;
          res.cell_y     = cur_y_q;
          x1             = x0 + cw_w;
        end
        x2 = x1;
        y2 = y1;
        if (x1 + cw_w > sw_w) begin
          x2 = '0;
          y2 = y1 + lh_w;
        end
        y3 = y2;
        if (y2 + lh_w > sh_w) begin
          res.scroll       = 1'b1;
          res.scroll_lines = (lh > LH_W'(2**LINES_W - 1)) ? '1 : lh[LINES_W-1:0];
          y3               = (y2 >= lh_w) ? y2 - lh_w : '0;
        end
        cur_x_d = (x2 > WORK_W'(COORD_MAX)) ? COORD_MAX : x2[COORD_W-1:0];
        cur_y_d = (y3 > WORK_W'(COORD_MAX)) ? COORD_MAX : y3[COORD_W-1:0];
      end
      FUNC_SET: begin
        cur_x_d = (nx_q > NX_W'(COORD_MAX)) ? COORD_MAX : nx_q[COORD_W-1:0];
        cur_y_d = (ny_q > NY_W'(COORD_MAX)) ? COORD_MAX : ny_q[COORD_W-1:0];
      end
      FUNC_CLEAR: begin
        res.action = ACT_CLEAR;
        cur_x_d    = '0;
        cur_y_d    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        cur_x_q     <= cur_x_d;
        cur_y_q     <= cur_y_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_CLK(a_commit_when_free, cmd_i.commit, !out_busy)
  `ASSERT_CLK_NEXT(a_commit_shows_item, cmd_i.commit, out_valid_q)
  `ASSERT_CLK(a_div_only_when_needed, cmd_i.div_start, sts_o.need_div)

endmodule

`default_nettype wire

### sv/text_cursor_controller_top.sv
// Text console cursor controller: one draw command per input command.
//
// Input channel (in_valid_i/in_ready_o, in_item_i) takes commands: put
// character, set cursor, clear screen. Output channel (out_valid_o/out_ready_i,
// out_item_o) gives exactly one draw command and scroll request per command.
// Display width, height and zoom are written over the APB-style port; the user
// must write them only while the block is idle; the block does not enforce it.
// pready is always high and reads return the register value.
//
// Each command is loaded, prepared and committed to the output register; for a
// backspace at line start an 11-step serial remainder unit first works out the
// last whole cell of the line above. The next command waits for the commit.
//
// Reset clears the cursor to 0,0, loads width 1024, height 768, zoom 2 and
// empties the output register. While the receiver stalls, the result is held;
// one further command is accepted and worked up to its final step, where it
// waits until the output register frees.
`default_nettype none

module text_cursor_controller_top
  import tcc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  in_item_t                   in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_item_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign pready = 1'b1;

  tcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  tcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### test/text_cursor_controller_top_tb.sv
// Testbench for the text cursor controller: directed and random commands, predicted.
module text_cursor_controller_top_tb;
  import tcc_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct {
    int unsigned width;
    int unsigned height;
    int unsigned zoom;
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned n_cmds;
    bit          pressure;
  } phase_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_item_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  text_cursor_controller_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: register copy and cursor
  logic [COORD_W-1:0] cfg_width  = WIDTH_RESET;
  logic [COORD_W-1:0] cfg_height = HEIGHT_RESET;
  logic [ZOOM_W-1:0]  cfg_zoom   = ZOOM_RESET;
  logic [COORD_W-1:0] cur_x = '0;
  logic [COORD_W-1:0] cur_y = '0;

  in_item_t    cmd_q[$];
  out_item_t   draw_q[$];
  out_item_t   want_draw;
  int unsigned cmds_issued = 0;
  int unsigned draws_seen = 0;
  int unsigned fail_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;

  phase_t plan [8] = '{
    '{2047, 2047,  1,  0,  0, 170, 1'b0},
    '{  64,   64,  8, 83,  0, 170, 1'b0},
    '{ 640,  480,  0,  0, 83, 170, 1'b0},
    '{ 100,  300, 15, 12, 12, 170, 1'b0},
    '{2047,   64,  3,  0,  0, 170, 1'b1},
    '{1000,  700,  5, 83,  0, 170, 1'b0},
    '{  37, 2000,  4,  0, 83, 170, 1'b0},
    '{1024,  768,  2, 12, 12, 170, 1'b0}
  };

  function automatic int unsigned eff_zoom();
    return (cfg_zoom == '0) ? 1 : int'(cfg_zoom);
  endfunction

  // Work out the draw command of one item and move the cursor
  function automatic out_item_t advance_cursor(in_item_t c);
    out_item_t   r;
    int unsigned cw, lh, x, y, cells;
    r = '0;
    cw = CELL_WIDTH * eff_zoom();
    lh = CELL_HEIGHT * eff_zoom();
    x = cur_x;
    y = cur_y;
    case (c.func)
      FUNC_PUT: begin
        if (c.char_code == CHAR_NEWLINE) begin
          x = 0;
          y += lh;
        end else if (c.char_code == CHAR_BACKSPACE) begin
          if (x >= cw) begin
            x -= cw;
            r.action = ACT_ERASE;
            r.glyph_code = CHAR_SPACE;
            r.cell_x = COORD_W'(x);
            r.cell_y = COORD_W'(y);
          end else if (x == 0 && y >= lh) begin
            // back up to the last whole cell of the line above
            cells = cfg_width / cw;
            y -= lh;
            x = (cells == 0) ? 0 : (cells - 1) * cw;
            r.action = ACT_ERASE;
            r.glyph_code = CHAR_SPACE;
            r.cell_x = COORD_W'(x);
            r.cell_y = COORD_W'(y);
          end
        end else begin
          r.action = ACT_GLYPH;
          r.glyph_code = c.char_code;
          r.cell_x = COORD_W'(x);
          r.cell_y = COORD_W'(y);
          x += cw;
        end
        if (x + cw > cfg_width) begin
          x = 0;
          y += lh;
        end
        if (y + lh > cfg_height) begin
          r.scroll = 1'b1;
          r.scroll_lines = LINES_W'((lh > 255) ? 255 : lh);
          y = (y >= lh) ? y - lh : 0;
        end
        cur_x = COORD_W'((x > COORD_MAX) ? COORD_MAX : x);
        cur_y = COORD_W'((y > COORD_MAX) ? COORD_MAX : y);
      end
      FUNC_SET: begin
        x = cw * c.column;
        y = lh * c.row;
        cur_x = COORD_W'((x > COORD_MAX) ? COORD_MAX : x);
        cur_y = COORD_W'((y > COORD_MAX) ? COORD_MAX : y);
      end
      FUNC_CLEAR: begin
        r.action = ACT_CLEAR;
        cur_x = '0;
        cur_y = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t make_cmd(logic [1:0] f, int unsigned ch, int unsigned col,
                                        int unsigned row);
    in_item_t c;
    c.func = f;
    c.char_code = CHAR_W'(ch);
    c.column = COL_W'(col);
    c.row = ROW_W'(row);
    return c;
  endfunction

  // Mostly text with edits, some cursor moves on or past the screen, a little noise
  function automatic in_item_t random_cmd();
    in_item_t    c;
    int unsigned pick, cells, lines;
    c.char_code = CHAR_W'($urandom_range(255));
    c.column = COL_W'($urandom_range(255));
    c.row = ROW_W'($urandom_range(127));
    pick = $urandom_range(99);
    if (pick < 74) begin
      c.func = FUNC_PUT;
      pick = $urandom_range(9);
      if (pick == 0) c.char_code = CHAR_NEWLINE;
      else if (pick < 3) c.char_code = CHAR_BACKSPACE;
    end else if (pick < 92) begin
      c.func = FUNC_SET;
      if ($urandom_range(3) != 0) begin
        cells = cfg_width / (CELL_WIDTH * eff_zoom());
        lines = cfg_height / (CELL_HEIGHT * eff_zoom());
        c.column = COL_W'($urandom_range((cells > 255) ? 255 : cells));
        c.row = ROW_W'($urandom_range((lines > 127) ? 127 : lines));
      end
    end else if (pick < 96) begin
      c.func = FUNC_CLEAR;
    end else begin
      c.func = FUNC_UNUSED;
    end
    return c;
  endfunction

  function automatic logic [APB_DATA_W-1:0] reg_value(reg_e idx);
    case (idx)
      REG_DISP_WIDTH:  return APB_DATA_W'(cfg_width);
      REG_DISP_HEIGHT: return APB_DATA_W'(cfg_height);
      default:         return APB_DATA_W'(cfg_zoom);
    endcase
  endfunction

  task automatic read_reg(input reg_e idx);
    logic [APB_DATA_W-1:0] got, mask;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= APB_ADDR_W'(4 * idx);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    mask = (idx == REG_ZOOM) ? APB_DATA_W'(ZOOM_MAX) : APB_DATA_W'(COORD_MAX);
    if ((got & mask) != reg_value(idx)) begin
      $error("register %s: expected %0d, got %0d", idx.name(), reg_value(idx), got & mask);
      fail_cnt++;
    end
  endtask

  task automatic write_reg(input reg_e idx, input int unsigned val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * idx);
    pwdata <= APB_DATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DISP_WIDTH:  cfg_width = COORD_W'(val);
      REG_DISP_HEIGHT: cfg_height = COORD_W'(val);
      default:         cfg_zoom = ZOOM_W'(val);
    endcase
    read_reg(idx);
  endtask

  task automatic queue_cmd(input in_item_t c);
    cmd_q.push_back(c);
    cmds_issued++;
  endtask

  task automatic wait_drained();
    while (draws_seen < cmds_issued) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Driver: predict on acceptance, then offer the next pending item
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) draw_q.push_back(advance_cursor(in_item_i));
      if (!in_valid_i || in_ready_o) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_item_i <= cmd_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        draws_seen++;
        if (draw_q.size() == 0) begin
          $error("result with nothing expected: %p", out_item_o);
          fail_cnt++;
        end else begin
          want_draw = draw_q.pop_front();
          check_field("action", want_draw.action, out_item_o.action);
          check_field("glyph_code", want_draw.glyph_code, out_item_o.glyph_code);
          check_field("cell_x", want_draw.cell_x, out_item_o.cell_x);
          check_field("cell_y", want_draw.cell_y, out_item_o.cell_y);
          check_field("scroll", want_draw.scroll, out_item_o.scroll);
          check_field("scroll_lines", want_draw.scroll_lines, out_item_o.scroll_lines);
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long receiver hold-off so the block backs up into its input
  always @(posedge clk_i) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    read_reg(REG_DISP_WIDTH);
    read_reg(REG_DISP_HEIGHT);
    read_reg(REG_ZOOM);

    // Directed commands on the reset setting
    @(negedge clk_i);
    idle_pct = 12;
    stall_pct = 12;
    queue_cmd(make_cmd(FUNC_CLEAR, 0, 0, 0));
    queue_cmd(make_cmd(FUNC_PUT, CHAR_BACKSPACE, 0, 0));
    queue_cmd(make_cmd(FUNC_PUT, 65, 0, 0));
    queue_cmd(make_cmd(FUNC_PUT, 0, 255, 127));
    queue_cmd(make_cmd(FUNC_PUT, 255, 0, 0));
    queue_cmd(make_cmd(FUNC_PUT, CHAR_BACKSPACE, 0, 0));
    queue_cmd(make_cmd(FUNC_PUT, CHAR_NEWLINE, 0, 0));
    queue_cmd(make_cmd(FUNC_PUT, CHAR_BACKSPACE, 0, 0));
    queue_cmd(make_cmd(FUNC_SET, 0, 63, 0));
    queue_cmd(make_cmd(FUNC_PUT, 90, 0, 0));
    queue_cmd(make_cmd(FUNC_SET, 0, 255, 127));
    queue_cmd(make_cmd(FUNC_PUT, 113, 0, 0));
    queue_cmd(make_cmd(FUNC_SET, 0, 0, 23));
    queue_cmd(make_cmd(FUNC_PUT, CHAR_NEWLINE, 0, 0));
    queue_cmd(make_cmd(FUNC_UNUSED, 170, 85, 42));
    queue_cmd(make_cmd(FUNC_SET, 0, 10, 5));
    queue_cmd(make_cmd(FUNC_PUT, CHAR_BACKSPACE, 0, 0));
    queue_cmd(make_cmd(FUNC_CLEAR, 255, 255, 127));
    queue_cmd(make_cmd(FUNC_SET, 0, 1, 3));
    wait_drained();

    // Larger cells leave the cursor off the grid: backspace does nothing
    write_reg(REG_ZOOM, 8);
    @(negedge clk_i);
    queue_cmd(make_cmd(FUNC_PUT, CHAR_BACKSPACE, 0, 0));
    queue_cmd(make_cmd(FUNC_PUT, 120, 0, 0));
    queue_cmd(make_cmd(FUNC_PUT, CHAR_NEWLINE, 0, 0));
    wait_drained();

    foreach (plan[p]) begin
      write_reg(REG_DISP_WIDTH, plan[p].width);
      write_reg(REG_DISP_HEIGHT, plan[p].height);
      write_reg(REG_ZOOM, plan[p].zoom);
      @(negedge clk_i);
      idle_pct = plan[p].idle_pct;
      stall_pct = plan[p].stall_pct;
      repeat (plan[p].n_cmds) queue_cmd(random_cmd());
      if (plan[p].pressure) begin
        hold_req = 1'b1;
        @(negedge clk_i);
        hold_req = 1'b0;
      end
      wait_drained();
    end

    repeat (30) @(posedge clk_i);
    if (draw_q.size() != 0) begin
      $error("%0d expected results never arrived", draw_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/tcc_pkg.sv
sv/tcc_regs.sv
sv/tcc_ctrl.sv
sv/tcc_dp.sv
sv/text_cursor_controller_top.sv
test/text_cursor_controller_top_tb.sv
